>>> hw/rtl/first_fit_grid_span_placer_core_macros.svh
// Assertion macros used by the placer core RTL.
`ifndef FIRST_FIT_GRID_SPAN_PLACER_CORE_MACROS_SVH
`define FIRST_FIT_GRID_SPAN_PLACER_CORE_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define FFGSP_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("placer assertion failed");

// Next-cycle implication, disabled in reset.
`define FFGSP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("placer assertion failed");

`endif

>>> hw/rtl/ffgsp_pkg.sv
// Shared types and constants of the first-fit grid span placer.
package ffgsp_pkg;

   localparam int SPAN_W        = 5;
   localparam int POS_W         = 4;
   localparam int DEF_GRID_ROWS = 16;
   localparam int DEF_GRID_COLS = 16;

   localparam logic STATUS_PLACED   = 1'b0;
   localparam logic STATUS_NO_SPACE = 1'b1;

   typedef struct packed {
      logic              start_req;
      logic [SPAN_W-1:0] span_rows;
      logic [SPAN_W-1:0] span_cols;
   } req_type;

   typedef struct packed {
      logic [POS_W-1:0]  cell_row;
      logic [POS_W-1:0]  cell_column;
      logic [SPAN_W-1:0] used_row_span;
      logic [SPAN_W-1:0] used_col_span;
      logic              status;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_MARK_RD,
      ST_MARK_WR,
      ST_DONE
   } state_type;

endpackage

>>> hw/rtl/ffgsp_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ffgsp_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hw/rtl/first_fit_grid_span_placer_core.sv
// Top level of the first-fit grid span placer: sequencer, fit unit and occupancy RAM.
//
//   channel   ports                              direction  handshake
//   request   start, busy, req_data              in         start & !busy
//   response  rsp_valid, rsp_data                out        one-cycle strobe
//   csr       csr_valid, csr_ready, csr_data     in         valid & ready
//
// Flow: accept -> SCAN reads one grid row per cycle (registered RAM read)
// and the fit unit tests every column origin of that row at once; for a
// placed item the scan ends at row origin_row + used_row_span - 1. Marking
// then reads and writes back each covered row in turn (MARK_RD, MARK_WR),
// and DONE raises the response strobe. An item after an earlier failure
// goes straight to DONE without a scan. No new item is taken before the
// response strobe (busy is high outside IDLE).
// Reset is synchronous; grid rows carry valid bits cleared by reset or by a
// start_req item, so no clearing pass is needed. The response cannot stall.
module first_fit_grid_span_placer_core #(
   parameter int GRID_ROWS = ffgsp_pkg::DEF_GRID_ROWS,
   parameter int GRID_COLS = ffgsp_pkg::DEF_GRID_COLS
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  ffgsp_pkg::req_type        req_data,
   output logic                      rsp_valid,
   output ffgsp_pkg::rsp_type        rsp_data,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [ffgsp_pkg::SPAN_W-1:0] csr_data
);

   import ffgsp_pkg::*;

`include "first_fit_grid_span_placer_core_macros.svh"

   localparam int ROW_W  = (GRID_ROWS > 1) ? $clog2(GRID_ROWS) : 1;
   localparam int RCNT_W = $clog2(GRID_ROWS + 1);
   localparam int COL_W  = (GRID_COLS > 1) ? $clog2(GRID_COLS) : 1;
   localparam int CCNT_W = $clog2(GRID_COLS + 1);
   localparam int HGT_W  = SPAN_W;
   localparam logic [HGT_W-1:0] HGT_MAX = {HGT_W{1'b1}};
   localparam int RSUM_W = ((RCNT_W > SPAN_W) ? RCNT_W : SPAN_W) + 1;
   localparam int CSUM_W = ((CCNT_W > SPAN_W) ? CCNT_W : SPAN_W) + 1;

   // control state
   state_type             state_ff, state_in;
   logic [SPAN_W-1:0]     column_count_ff, column_count_in;
   logic                  failed_ff, failed_in;
   logic [GRID_ROWS-1:0]  row_vld_ff, row_vld_in;
   logic                  proc_vld_ff, proc_vld_in;

   // per-item working registers
   logic [CCNT_W-1:0]     cols_ff, cols_in;
   logic [SPAN_W-1:0]     rs_ff, rs_in;
   logic [SPAN_W-1:0]     cs_ff, cs_in;
   logic [GRID_COLS-1:0]  win_ff, win_in;
   logic [RCNT_W-1:0]     issue_ff, issue_in;
   logic [ROW_W-1:0]      proc_row_ff, proc_row_in;
   logic [HGT_W-1:0]      hgt_ff [GRID_COLS];
   logic [HGT_W-1:0]      hgt_in [GRID_COLS];
   logic [ROW_W-1:0]      org_row_ff, org_row_in;
   logic [COL_W-1:0]      org_col_ff, org_col_in;
   logic [ROW_W-1:0]      mark_row_ff, mark_row_in;
   logic [SPAN_W-1:0]     mark_left_ff, mark_left_in;
   logic                  rd_vld_ff, rd_vld_in;
   rsp_type               rsp_ff, rsp_in;

   // RAM port
   logic                  ram_wr_en, ram_rd_en;
   logic [ROW_W-1:0]      ram_wr_addr, ram_rd_addr;
   logic [GRID_COLS-1:0]  ram_wr_data, ram_rd_data;
   logic [GRID_COLS-1:0]  row_occ;

   // fit unit
   logic [HGT_W-1:0]      hgt_new [GRID_COLS];
   logic [GRID_COLS-1:0]  col_ok;
   logic [GRID_COLS-1:0]  col_fit;
   logic                  fit_hit;
   logic [COL_W-1:0]      fit_col;

   ffgsp_ram #(
      .WIDTH (GRID_COLS),
      .DEPTH (GRID_ROWS),
      .ADDR_W(ROW_W)
   ) u_occ_ram (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(ram_wr_addr),
      .wr_data(ram_wr_data),
      .rd_en  (ram_rd_en),
      .rd_addr(ram_rd_addr),
      .rd_data(ram_rd_data)
   );

   // a row never written since the last clear reads as all free
   assign row_occ = ram_rd_data & {GRID_COLS{rd_vld_ff}};

   // Fit unit: column heights of free cells ending at the row just read,
   // then every origin column of the window tested in parallel.
   always_comb begin
      for (int c = 0; c < GRID_COLS; c++) begin
         if (row_occ[c]) begin
            hgt_new[c] = '0;
         end else if (hgt_ff[c] == HGT_MAX) begin
            hgt_new[c] = HGT_MAX;
         end else begin
            hgt_new[c] = hgt_ff[c] + 1'b1;
         end
         col_ok[c] = (hgt_new[c] >= rs_ff);
      end
      for (int c = 0; c < GRID_COLS; c++) begin
         col_fit[c] = ((CSUM_W'(c) + CSUM_W'(cs_ff)) <= CSUM_W'(cols_ff)) &&
                      (((col_ok >> c) & win_ff) == win_ff);
      end
      fit_hit = 1'b0;
      fit_col = '0;
      for (int c = GRID_COLS - 1; c >= 0; c--) begin
         if (col_fit[c]) begin
            fit_hit = 1'b1;
            fit_col = COL_W'(c);
         end
      end
   end

   // Sequencer: next state and datapath controls.
   always_comb begin
      logic [SPAN_W-1:0] cc_nz;
      logic [SPAN_W-1:0] rs_nz;
      logic [SPAN_W-1:0] cs_nz;
      logic [CSUM_W-1:0] cc_wide;
      logic [RSUM_W-1:0] org_sum;

      state_in        = state_ff;
      column_count_in = column_count_ff;
      failed_in       = failed_ff;
      row_vld_in      = row_vld_ff;
      proc_vld_in     = 1'b0;
      cols_in         = cols_ff;
      rs_in           = rs_ff;
      cs_in           = cs_ff;
      win_in          = win_ff;
      issue_in        = issue_ff;
      proc_row_in     = proc_row_ff;
      hgt_in          = hgt_ff;
      org_row_in      = org_row_ff;
      org_col_in      = org_col_ff;
      mark_row_in     = mark_row_ff;
      mark_left_in    = mark_left_ff;
      rd_vld_in       = rd_vld_ff;
      rsp_in          = rsp_ff;
      ram_wr_en       = 1'b0;
      ram_wr_addr     = mark_row_ff;
      ram_wr_data     = row_occ | (win_ff << org_col_ff);
      ram_rd_en       = 1'b0;
      ram_rd_addr     = issue_ff[ROW_W-1:0];
      cc_nz           = '0;
      rs_nz           = '0;
      cs_nz           = '0;
      cc_wide         = '0;
      org_sum         = '0;

      if (csr_valid) begin
         column_count_in = csr_data;
      end

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cc_nz   = (column_count_ff == '0) ? SPAN_W'(1) : column_count_ff;
               cc_wide = CSUM_W'(cc_nz);
               if (cc_wide > CSUM_W'(GRID_COLS)) begin
                  cols_in = CCNT_W'(GRID_COLS);
               end else begin
                  cols_in = CCNT_W'(cc_wide);
               end
               rs_nz = (req_data.span_rows == '0) ? SPAN_W'(1) : req_data.span_rows;
               cs_nz = (req_data.span_cols == '0) ? SPAN_W'(1) : req_data.span_cols;
               if (CSUM_W'(cs_nz) > CSUM_W'(cols_in)) begin
                  cs_in = SPAN_W'(cols_in);
               end else begin
                  cs_in = cs_nz;
               end
               rs_in = rs_nz;
               for (int i = 0; i < GRID_COLS; i++) begin
                  win_in[i] = (CSUM_W'(i) < CSUM_W'(cs_in));
               end
               if (req_data.start_req) begin
                  row_vld_in = '0;
                  failed_in  = 1'b0;
               end
               issue_in = '0;
               for (int c = 0; c < GRID_COLS; c++) begin
                  hgt_in[c] = '0;
               end
               if (failed_ff && !req_data.start_req) begin
                  rsp_in.cell_row      = '0;
                  rsp_in.cell_column   = '0;
                  rsp_in.used_row_span = rs_in;
                  rsp_in.used_col_span = cs_in;
                  rsp_in.status        = STATUS_NO_SPACE;
                  state_in             = ST_DONE;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end

         ST_SCAN: begin
            // issue one row read per cycle, consume the previous one
            if (issue_ff < RCNT_W'(GRID_ROWS)) begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = issue_ff[ROW_W-1:0];
               rd_vld_in   = row_vld_ff[issue_ff[ROW_W-1:0]];
               issue_in    = issue_ff + 1'b1;
               proc_vld_in = 1'b1;
               proc_row_in = issue_ff[ROW_W-1:0];
            end
            if (proc_vld_ff) begin
               hgt_in = hgt_new;
               if (fit_hit) begin
                  org_sum      = RSUM_W'(proc_row_ff) + RSUM_W'(1) - RSUM_W'(rs_ff);
                  org_row_in   = org_sum[ROW_W-1:0];
                  org_col_in   = fit_col;
                  mark_row_in  = org_sum[ROW_W-1:0];
                  mark_left_in = rs_ff;
                  proc_vld_in  = 1'b0;
                  state_in     = ST_MARK_RD;
               end else if (RSUM_W'(proc_row_ff) == RSUM_W'(GRID_ROWS - 1)) begin
                  failed_in            = 1'b1;
                  rsp_in.cell_row      = '0;
                  rsp_in.cell_column   = '0;
                  rsp_in.used_row_span = rs_ff;
                  rsp_in.used_col_span = cs_ff;
                  rsp_in.status        = STATUS_NO_SPACE;
                  proc_vld_in          = 1'b0;
                  state_in             = ST_DONE;
               end
            end
         end

         ST_MARK_RD: begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = mark_row_ff;
            rd_vld_in   = row_vld_ff[mark_row_ff];
            state_in    = ST_MARK_WR;
         end

         ST_MARK_WR: begin
            ram_wr_en               = 1'b1;
            row_vld_in[mark_row_ff] = 1'b1;
            mark_row_in             = mark_row_ff + 1'b1;
            mark_left_in            = mark_left_ff - 1'b1;
            if (mark_left_ff == SPAN_W'(1)) begin
               rsp_in.cell_row      = POS_W'(org_row_ff);
               rsp_in.cell_column   = POS_W'(org_col_ff);
               rsp_in.used_row_span = rs_ff;
               rsp_in.used_col_span = cs_ff;
               rsp_in.status        = STATUS_PLACED;
               state_in             = ST_DONE;
            end else begin
               state_in = ST_MARK_RD;
            end
         end

         ST_DONE: begin
            state_in = ST_IDLE;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         column_count_ff <= SPAN_W'(1);
         failed_ff       <= 1'b0;
         row_vld_ff      <= '0;
         proc_vld_ff     <= 1'b0;
      end else begin
         state_ff        <= state_in;
         column_count_ff <= column_count_in;
         failed_ff       <= failed_in;
         row_vld_ff      <= row_vld_in;
         proc_vld_ff     <= proc_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      cols_ff      <= cols_in;
      rs_ff        <= rs_in;
      cs_ff        <= cs_in;
      win_ff       <= win_in;
      issue_ff     <= issue_in;
      proc_row_ff  <= proc_row_in;
      hgt_ff       <= hgt_in;
      org_row_ff   <= org_row_in;
      org_col_ff   <= org_col_in;
      mark_row_ff  <= mark_row_in;
      mark_left_ff <= mark_left_in;
      rd_vld_ff    <= rd_vld_in;
      rsp_ff       <= rsp_in;
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_DONE);
   assign rsp_data  = rsp_ff;
   assign csr_ready = 1'b1;

   // response strobe lasts exactly one cycle
   `FFGSP_ASSERT_NEXT(a_rsp_one_cycle, clock, reset, rsp_valid, !rsp_valid)
   // an accepted item makes the block busy
   `FFGSP_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy)
   // reported status agrees with the sticky failure flag
   `FFGSP_ASSERT_IMPLY(a_status_flag, clock, reset, rsp_valid, rsp_data.status == failed_ff)
   // a placed item lies inside the grid rows
   `FFGSP_ASSERT_IMPLY(a_placed_rows, clock, reset, rsp_valid && !rsp_data.status, (int'(rsp_data.cell_row) + int'(rsp_data.used_row_span)) <= GRID_ROWS)

endmodule

>>> tb/first_fit_grid_span_placer_core_test.sv
`timescale 1ns / 1ps
// Self-checking testbench of the first-fit grid span placer core.
module first_fit_grid_span_placer_core_test;
   import ffgsp_pkg::*;

   localparam int ROWS              = DEF_GRID_ROWS;
   localparam int COLS              = DEF_GRID_COLS;
   localparam int RESET_CYCLES      = 9;
   // Well above the worst item plus a sender gap; no progress for this
   // long means the block is hung.
   localparam int STALL_LIMIT       = 1000;
   // Every item yields a result, so a short settle before csr writes is enough.
   localparam int SETTLE_CYCLES     = 8;
   localparam int ITEMS_PER_SETTING = 50;
   localparam int N_DIRECTED        = 23;

   typedef enum logic {ROW_ITEM, ROW_CSR} row_kind_type;

   // One directed row: either a column count write or an item. The fixed
   // result applies only where the fixed flag is set.
   typedef struct {
      row_kind_type kind;
      int           csr_value;
      bit           start_req;
      int           span_rows;
      int           span_cols;
      bit           fixed;
      int           row;
      int           col;
      int           used_rs;
      int           used_cs;
      logic         status;
   } stim_row_type;

   logic              clock     = 1'b0;
   logic              reset     = 1'b1;
   logic              start     = 1'b0;
   logic              busy;
   req_type           req_data  = '0;
   logic              rsp_valid;
   rsp_type           rsp_data;
   logic              csr_valid = 1'b0;
   logic              csr_ready;
   logic [SPAN_W-1:0] csr_data  = '0;

   first_fit_grid_span_placer_core dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   always begin
      #4 clock = ~clock;
   end

   // Placement predictor state: occupancy grid, sticky failure, column count.
   logic [COLS-1:0]   grid_model [ROWS];
   logic              grid_failed;
   logic [SPAN_W-1:0] column_setting;

   rsp_type           placements_due[$];
   stim_row_type      directed_rows[N_DIRECTED];

   int error_count     = 0;
   int items_sent      = 0;
   int placed_count    = 0;
   int refused_count   = 0;
   int csr_writes      = 0;
   int sender_idle_pct = 0;
   int quiet_cycles    = 0;

   // First-fit placement: rows from the top, columns from the left. Updates
   // the grid model and returns the result the block must report.
   function automatic rsp_type place_item(req_type item);
      int              cols, rs, cs, found_row, found_col;
      bit              found, fits;
      logic [COLS-1:0] span_mask, found_mask;
      rsp_type         placed;
      if (item.start_req) begin
         foreach (grid_model[i]) grid_model[i] = '0;
         grid_failed = 1'b0;
      end
      cols = (column_setting == 0) ? 1 : int'(column_setting);
      if (cols > COLS) cols = COLS;
      rs = (item.span_rows == 0) ? 1 : int'(item.span_rows);
      cs = (item.span_cols == 0) ? 1 : int'(item.span_cols);
      if (cs > cols) cs = cols;
      found      = 1'b0;
      found_row  = 0;
      found_col  = 0;
      found_mask = '0;
      // After a failure the grid is frozen until a start item.
      if (!grid_failed) begin
         for (int row = 0; row < ROWS && !found; row++) begin
            for (int col = 0; col < cols && !found; col++) begin
               fits      = (col + cs <= cols) && (row + rs <= ROWS);
               span_mask = '0;
               for (int x = col; x < col + cs && x < COLS; x++) span_mask[x] = 1'b1;
               for (int y = row; fits && y < row + rs; y++) begin
                  if ((grid_model[y] & span_mask) != '0) fits = 1'b0;
               end
               if (fits) begin
                  found      = 1'b1;
                  found_row  = row;
                  found_col  = col;
                  found_mask = span_mask;
               end
            end
         end
         if (found) begin
            for (int y = found_row; y < found_row + rs; y++) grid_model[y] |= found_mask;
         end else begin
            grid_failed = 1'b1;
         end
      end
      placed.cell_row      = found ? POS_W'(found_row) : '0;
      placed.cell_column   = found ? POS_W'(found_col) : '0;
      placed.used_row_span = SPAN_W'(rs);
      placed.used_col_span = SPAN_W'(cs);
      placed.status        = found ? STATUS_PLACED : STATUS_NO_SPACE;
      return placed;
   endfunction

   // Mostly small spans so the grid fills over many placements; now and then
   // a full-grid or out-of-range span. Start items mostly follow a failure.
   function automatic logic [SPAN_W-1:0] random_span();
      case ($urandom_range(0, 9))
         0:       return SPAN_W'($urandom_range(0, 31));
         1, 2:    return SPAN_W'($urandom_range(0, 16));
         default: return SPAN_W'($urandom_range(0, 3));
      endcase
   endfunction

   function automatic req_type random_item();
      req_type item;
      item.start_req = (grid_failed && $urandom_range(0, 3) != 0) ||
                       ($urandom_range(0, 39) == 0);
      item.span_rows = random_span();
      item.span_cols = random_span();
      return item;
   endfunction

   // Present one item, hold it until the block takes it, then log what the
   // block has to answer. An optional gap idles the request line first.
   task automatic send_item(req_type item, rsp_type fixed_rsp, bit use_fixed);
      rsp_type predicted;
      if ($urandom_range(0, 99) < sender_idle_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      start    <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (busy);
      predicted = place_item(item);
      placements_due.push_back(use_fixed ? fixed_rsp : predicted);
      items_sent++;
   endtask

   // Hold the request line low until every outstanding result is back.
   task automatic wait_for_drain();
      start <= 1'b0;
      while (placements_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Column count is only changed with the block idle.
   task automatic write_column_count(logic [SPAN_W-1:0] value);
      wait_for_drain();
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid      <= 1'b0;
      column_setting  = value;
      csr_writes++;
   endtask

   task automatic check_field(string name, logic [SPAN_W-1:0] due, logic [SPAN_W-1:0] got);
      if (got !== due) begin
         $display("%0t: %s expected %0d, got %0d", $time, name, due, got);
         error_count++;
      end
   endtask

   // Result checker: every strobe must match the oldest outstanding item.
   always @(posedge clock) begin
      rsp_type due;
      if (!reset && rsp_valid) begin
         if (placements_due.size() == 0) begin
            $display("%0t: result with no item outstanding, got %p", $time, rsp_data);
            error_count++;
         end else begin
            due = placements_due.pop_front();
            check_field("cell_row", SPAN_W'(due.cell_row), SPAN_W'(rsp_data.cell_row));
            check_field("cell_column", SPAN_W'(due.cell_column),
                        SPAN_W'(rsp_data.cell_column));
            check_field("used_row_span", due.used_row_span, rsp_data.used_row_span);
            check_field("used_col_span", due.used_col_span, rsp_data.used_col_span);
            check_field("status", SPAN_W'(due.status), SPAN_W'(rsp_data.status));
            if (rsp_data.status == STATUS_PLACED) placed_count++;
            else refused_count++;
         end
      end
   end

   // Watchdog: any accepted item, result or csr write counts as progress.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles + 1 >= STALL_LIMIT) begin
            $display("%0t: no progress for %0d cycles, %0d results outstanding",
                     $time, STALL_LIMIT, placements_due.size());
            $display("FAIL first_fit_grid_span_placer_core");
            $finish;
         end
      end
   end

   initial begin
      stim_row_type row;
      req_type      item;
      rsp_type      fixed_rsp;

      // kind, csr, start, rs, cs, fixed, row, col, used rs, used cs, status
      directed_rows = '{
         // reset column count is one: zero spans default to one
         '{ROW_ITEM, 0,  1, 0,  0,  1, 0, 0, 1,  1,  STATUS_PLACED},
         // col span clamped to the single column, stacks below
         '{ROW_ITEM, 0,  0, 1,  16, 1, 1, 0, 1,  1,  STATUS_PLACED},
         '{ROW_CSR,  16, 0, 0,  0,  0, 0, 0, 0,  0,  STATUS_PLACED},
         // whole grid in one item, then nothing fits
         '{ROW_ITEM, 0,  1, 16, 16, 1, 0, 0, 16, 16, STATUS_PLACED},
         '{ROW_ITEM, 0,  0, 1,  1,  1, 0, 0, 1,  1,  STATUS_NO_SPACE},
         // sticky failure: even a tiny item is refused
         '{ROW_ITEM, 0,  0, 0,  0,  1, 0, 0, 1,  1,  STATUS_NO_SPACE},
         // row span taller than the grid
         '{ROW_ITEM, 0,  1, 17, 0,  1, 0, 0, 17, 1,  STATUS_NO_SPACE},
         '{ROW_ITEM, 0,  1, 31, 31, 1, 0, 0, 31, 16, STATUS_NO_SPACE},
         // partial fills, first fit found by scanning
         '{ROW_ITEM, 0,  1, 2,  3,  1, 0, 0, 2,  3,  STATUS_PLACED},
         '{ROW_ITEM, 0,  0, 1,  16, 0, 0, 0, 0,  0,  STATUS_PLACED},
         '{ROW_ITEM, 0,  0, 2,  13, 0, 0, 0, 0,  0,  STATUS_PLACED},
         // zero column count acts as one
         '{ROW_CSR,  0,  0, 0,  0,  0, 0, 0, 0,  0,  STATUS_PLACED},
         '{ROW_ITEM, 0,  1, 16, 5,  1, 0, 0, 16, 1,  STATUS_PLACED},
         '{ROW_ITEM, 0,  0, 1,  1,  1, 0, 0, 1,  1,  STATUS_NO_SPACE},
         // count above the grid width clamps to it
         '{ROW_CSR,  31, 0, 0,  0,  0, 0, 0, 0,  0,  STATUS_PLACED},
         '{ROW_ITEM, 0,  1, 15, 0,  1, 0, 0, 15, 1,  STATUS_PLACED},
         '{ROW_ITEM, 0,  0, 1,  31, 0, 0, 0, 0,  0,  STATUS_PLACED},
         '{ROW_ITEM, 0,  0, 0,  15, 0, 0, 0, 0,  0,  STATUS_PLACED},
         '{ROW_CSR,  5,  0, 0,  0,  0, 0, 0, 0,  0,  STATUS_PLACED},
         '{ROW_ITEM, 0,  1, 4,  6,  1, 0, 0, 4,  5,  STATUS_PLACED},
         // fails on a partly used grid, then a start item recovers
         '{ROW_ITEM, 0,  0, 16, 1,  0, 0, 0, 0,  0,  STATUS_PLACED},
         '{ROW_ITEM, 0,  1, 1,  1,  1, 0, 0, 1,  1,  STATUS_PLACED},
         '{ROW_ITEM, 0,  1, 16, 16, 1, 0, 0, 16, 5,  STATUS_PLACED}
      };

      foreach (grid_model[i]) grid_model[i] = '0;
      grid_failed     = 1'b0;
      column_setting  = SPAN_W'(1);
      sender_idle_pct = 31;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         if (row.kind == ROW_CSR) begin
            write_column_count(SPAN_W'(row.csr_value));
         end else begin
            item.start_req        = row.start_req;
            item.span_rows        = SPAN_W'(row.span_rows);
            item.span_cols        = SPAN_W'(row.span_cols);
            fixed_rsp.cell_row      = POS_W'(row.row);
            fixed_rsp.cell_column   = POS_W'(row.col);
            fixed_rsp.used_row_span = SPAN_W'(row.used_rs);
            fixed_rsp.used_col_span = SPAN_W'(row.used_cs);
            fixed_rsp.status        = row.status;
            send_item(item, fixed_rsp, row.fixed);
         end
      end

      // Random part: light sender gaps, heavy gaps, then back to back. Each
      // phase walks several column counts, extremes among them; each csr
      // write also drains the pipe with the request line held low.
      for (int phase = 0; phase < 3; phase++) begin
         sender_idle_pct = (phase == 0) ? 31 : (phase == 1) ? 81 : 0;
         for (int setting = 0; setting < 3; setting++) begin
            case ($urandom_range(0, 5))
               0:       write_column_count(SPAN_W'(0));
               1:       write_column_count(SPAN_W'(1));
               2:       write_column_count(SPAN_W'(COLS));
               3:       write_column_count(SPAN_W'(31));
               default: write_column_count(SPAN_W'($urandom_range(2, 15)));
            endcase
            repeat (ITEMS_PER_SETTING) send_item(random_item(), '0, 1'b0);
         end
      end

      wait_for_drain();

      $display("%0d items over %0d column count writes, three sender gap profiles",
               items_sent, csr_writes);
      $display("%0d placed, %0d refused (no space or sticky failure), %0d mismatches",
               placed_count, refused_count, error_count);
      if (error_count == 0 && placements_due.size() == 0) begin
         $display("PASS first_fit_grid_span_placer_core");
      end else begin
         $display("FAIL first_fit_grid_span_placer_core");
      end
      $finish;
   end

endmodule
